/* rtl/assert_macros.svh */
// Assertion macros used by the checker file jsu_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on clk, off while arst_n is low.
`define CHK_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/jsu_pkg.sv */
`timescale 1ns / 1ps
package jsu_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	localparam logic [3:0] ST_CONT     = 4'd0;
	localparam logic [3:0] ST_DONE     = 4'd1;
	localparam logic [3:0] ST_BAD_HEX  = 4'd2;
	localparam logic [3:0] ST_UNP_HIGH = 4'd3;
	localparam logic [3:0] ST_BAD_LOW  = 4'd4;
	localparam logic [3:0] ST_UNP_LOW  = 4'd5;
	localparam logic [3:0] ST_BAD_ESC  = 4'd6;
	localparam logic [3:0] ST_CTRL     = 4'd7;
	localparam logic [3:0] ST_UNT_ESC  = 4'd8;
	localparam logic [3:0] ST_UNT_STR  = 4'd9;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      nlast;
		logic            has_data;
		logic [3:0]      status;
	} entry_t;

	typedef struct packed {
		logic [3:0][7:0] b;
		logic [1:0]      nlast;
	} utf8_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_dec(input logic [7:0] c);
		hex_t r;
		r.ok  = 1'b1;
		r.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.val = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r.val = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r.val = 4'(c - 8'h37);
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

	function automatic utf8_t utf8_enc(input logic [20:0] cp);
		utf8_t r;
		r.b = '0;
		if (cp < 21'h80) begin
			r.b[0]  = cp[7:0];
			r.nlast = 2'd0;
		end else if (cp < 21'h800) begin
			r.b[0]  = {3'b110, cp[10:6]};
			r.b[1]  = {2'b10, cp[5:0]};
			r.nlast = 2'd1;
		end else if (cp < 21'h10000) begin
			r.b[0]  = {4'b1110, cp[15:12]};
			r.b[1]  = {2'b10, cp[11:6]};
			r.b[2]  = {2'b10, cp[5:0]};
			r.nlast = 2'd2;
		end else begin
			r.b[0]  = {5'b11110, cp[20:18]};
			r.b[1]  = {2'b10, cp[17:12]};
			r.b[2]  = {2'b10, cp[11:6]};
			r.b[3]  = {2'b10, cp[5:0]};
			r.nlast = 2'd3;
		end
		return r;
	endfunction

endpackage

/* rtl/jsu_front.sv */
`timescale 1ns / 1ps
module jsu_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  logic [7:0]        char_byte,
	output jsu_pkg::entry_t   entry
);

	localparam logic [2:0] M_NORMAL  = 3'd0;
	localparam logic [2:0] M_ESCAPE  = 3'd1;
	localparam logic [2:0] M_HEX_HI  = 3'd2;
	localparam logic [2:0] M_WANT_BS = 3'd3;
	localparam logic [2:0] M_WANT_U  = 3'd4;
	localparam logic [2:0] M_HEX_LO  = 3'd5;

	logic [2:0]  mode_q, mode_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [11:0] acc_q, acc_d;
	logic [9:0]  high_q, high_d;

	jsu_pkg::hex_t  hx;
	jsu_pkg::utf8_t enc;
	logic [15:0]    code;
	logic [20:0]    pair_cp;

	assign hx      = jsu_pkg::hex_dec(char_byte);
	assign code    = {acc_q, hx.val};
	assign pair_cp = 21'h10000 + {1'b0, high_q, code[9:0]};

	always_comb begin
		mode_d         = mode_q;
		cnt_d          = cnt_q;
		acc_d          = acc_q;
		high_d         = high_q;
		entry          = '0;
		entry.status   = jsu_pkg::ST_CONT;
		enc            = '0;
		case (mode_q)
			M_NORMAL: begin
				if (char_byte == 8'h00) begin
					entry.status = jsu_pkg::ST_UNT_STR;
				end else if (char_byte == 8'h22) begin
					entry.status = jsu_pkg::ST_DONE;
				end else if (char_byte == 8'h5C) begin
					mode_d = M_ESCAPE;
				end else if (char_byte < 8'h20) begin
					entry.status = jsu_pkg::ST_CTRL;
				end else begin
					entry.has_data = 1'b1;
					entry.bytes[0] = char_byte;
				end
			end
			M_ESCAPE: begin
				mode_d = M_NORMAL;
				entry.has_data = 1'b1;
				case (char_byte)
					8'h00: begin
						entry.has_data = 1'b0;
						entry.status   = jsu_pkg::ST_UNT_ESC;
					end
					8'h22: entry.bytes[0] = 8'h22;
					8'h5C: entry.bytes[0] = 8'h5C;
					8'h2F: entry.bytes[0] = 8'h2F;
					8'h62: entry.bytes[0] = 8'h08;
					8'h66: entry.bytes[0] = 8'h0C;
					8'h6E: entry.bytes[0] = 8'h0A;
					8'h72: entry.bytes[0] = 8'h0D;
					8'h74: entry.bytes[0] = 8'h09;
					8'h75: begin
						entry.has_data = 1'b0;
						mode_d         = M_HEX_HI;
						cnt_d          = 2'd0;
						acc_d          = '0;
					end
					default: begin
						entry.has_data = 1'b0;
						entry.status   = jsu_pkg::ST_BAD_ESC;
					end
				endcase
			end
			M_HEX_HI, M_HEX_LO: begin
				if (!hx.ok) begin
					entry.status = jsu_pkg::ST_BAD_HEX;
				end else if (cnt_q != 2'd3) begin
					acc_d = {acc_q[7:0], hx.val};
					cnt_d = cnt_q + 2'd1;
				end else begin
					cnt_d = 2'd0;
					acc_d = '0;
					if (mode_q == M_HEX_HI) begin
						if (code[15:10] == 6'b110110) begin
							high_d = code[9:0];
							mode_d = M_WANT_BS;
						end else if (code[15:10] == 6'b110111) begin
							entry.status = jsu_pkg::ST_UNP_LOW;
						end else begin
							enc            = jsu_pkg::utf8_enc({5'd0, code});
							entry.has_data = 1'b1;
							entry.bytes    = enc.b;
							entry.nlast    = enc.nlast;
							mode_d         = M_NORMAL;
						end
					end else begin
						if (code[15:10] != 6'b110111) begin
							entry.status = jsu_pkg::ST_BAD_LOW;
						end else begin
							enc            = jsu_pkg::utf8_enc(pair_cp);
							entry.has_data = 1'b1;
							entry.bytes    = enc.b;
							entry.nlast    = enc.nlast;
							high_d         = '0;
							mode_d         = M_NORMAL;
						end
					end
				end
			end
			M_WANT_BS: begin
				if (char_byte == 8'h5C) begin
					mode_d = M_WANT_U;
				end else begin
					entry.status = jsu_pkg::ST_UNP_HIGH;
				end
			end
			M_WANT_U: begin
				if (char_byte == 8'h75) begin
					mode_d = M_HEX_LO;
					cnt_d  = 2'd0;
					acc_d  = '0;
				end else begin
					entry.status = jsu_pkg::ST_UNP_HIGH;
				end
			end
			default: begin
				entry.status = jsu_pkg::ST_UNT_STR;
			end
		endcase
		if (entry.status != jsu_pkg::ST_CONT) begin
			mode_d = M_NORMAL;
			cnt_d  = 2'd0;
			acc_d  = '0;
			high_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_NORMAL;
			cnt_q  <= 2'd0;
			acc_q  <= '0;
			high_q <= '0;
		end else if (acc) begin
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
			acc_q  <= acc_d;
			high_q <= high_d;
		end
	end

endmodule

/* rtl/jsu_queue.sv */
`timescale 1ns / 1ps
module jsu_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  jsu_pkg::entry_t   wr_entry,
	input  logic              rd,
	output jsu_pkg::entry_t   head,
	output logic              q_full,
	output logic              q_empty
);

	jsu_pkg::entry_t            mem_q [jsu_pkg::QDEPTH];
	logic [jsu_pkg::QAW-1:0]    wp_q, rp_q;
	logic [jsu_pkg::QAW:0]      cnt_q;

	assign head    = mem_q[rp_q];
	assign q_full  = (cnt_q == (jsu_pkg::QAW+1)'(jsu_pkg::QDEPTH));
	assign q_empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + (jsu_pkg::QAW)'(1);
			end
			if (rd) begin
				rp_q <= rp_q + (jsu_pkg::QAW)'(1);
			end
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + (jsu_pkg::QAW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (jsu_pkg::QAW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/jsu_back.sv */
`timescale 1ns / 1ps
module jsu_back (
	input  logic              clk,
	input  logic              arst_n,
	input  jsu_pkg::entry_t   head,
	input  logic              q_empty,
	input  logic              pop,
	output logic              deq,
	output logic [7:0]        data_byte,
	output logic              byte_valid,
	output logic [3:0]        status,
	output logic              last
);

	logic [1:0] k_q;
	logic       take;

	assign take       = pop & ~q_empty;
	assign last       = (k_q == head.nlast);
	assign deq        = take & last;
	assign byte_valid = head.has_data;
	assign data_byte  = head.has_data ? head.bytes[k_q] : 8'h00;
	assign status     = head.status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= 2'd0;
		end else if (take) begin
			k_q <= last ? 2'd0 : k_q + 2'd1;
		end
	end

endmodule

/* rtl/json_string_unescape_utf8.sv */
`timescale 1ns / 1ps
// channel  | handshake              | payload
// input    | push / full            | char_byte
// result   | empty / pop            | data_byte, byte_valid, status, last
//
// One input item per cycle unless full; decoder state updates in the accepting cycle.
// Each item becomes one entry of 1 to 4 result items, read one per cycle while popped.
// A four-entry queue separates decoder and serializer; full rises only when it is full.
// arst_n clears decoder state, queue pointers and the serializer's byte index.
module json_string_unescape_utf8 (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] data_byte,
	output logic       byte_valid,
	output logic [3:0] status,
	output logic       last
);

	jsu_pkg::entry_t new_entry, head;
	logic            acc, deq, q_empty;

	assign acc   = push & ~full;
	assign empty = q_empty;

	jsu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.char_byte (char_byte),
		.entry     (new_entry)
	);

	jsu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (acc),
		.wr_entry (new_entry),
		.rd       (deq),
		.head     (head),
		.q_full   (full),
		.q_empty  (q_empty)
	);

	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_empty    (q_empty),
		.pop        (pop),
		.deq        (deq),
		.data_byte  (data_byte),
		.byte_valid (byte_valid),
		.status     (status),
		.last       (last)
	);

endmodule

/* rtl/jsu_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module jsu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [7:0] data_byte,
	input logic       byte_valid,
	input logic [3:0] status,
	input logic       last
);

	logic        terminal;
	logic [13:0] shown_item;

	assign terminal   = !empty && (status != jsu_pkg::ST_CONT);
	assign shown_item = {data_byte, byte_valid, status, last};

	`CHK_ASSERT(a_status_range, !empty |-> (status <= jsu_pkg::ST_UNT_STR), "status out of range")
	`CHK_ASSERT(a_term_no_data, terminal |-> (!byte_valid && last), "terminal status with data")
	`CHK_ASSERT(a_nodata_single, (!empty && !byte_valid) |-> (last && data_byte == 8'h00), "bad empty item")
	`CHK_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(shown_item), "waiting item changed")
	`CHK_ASSERT_NEXT(a_accept_shows, push && !full, !empty, "accepted item not queued")

endmodule

bind json_string_unescape_utf8 jsu_checker u_chk (.*);

/* dv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
	import jsu_pkg::*;

	localparam int HALF_PERIOD  = 5;
	localparam int RESET_CYCLES = 8;
	localparam int RANDOM_ITEMS = 190;
	localparam int CALM_FIRST   = 70;
	localparam int CALM_LAST    = 130;
	localparam int IDLE_PCT     = 22;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int MAX_REPORTS  = 10;

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_B = 8'h42;
	localparam logic [7:0] CH_UPPER_D = 8'h44;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_B       = 8'h62;
	localparam logic [7:0] CH_LOWER_F = 8'h66;
	localparam logic [7:0] CH_N       = 8'h6E;
	localparam logic [7:0] CH_R       = 8'h72;
	localparam logic [7:0] CH_T       = 8'h74;
	localparam logic [7:0] CH_U       = 8'h75;
	localparam logic [7:0] CH_X       = 8'h78;
	localparam logic [7:0] CH_MAX     = 8'hFF;

	localparam logic [7:0] CTL_BS  = 8'h08;
	localparam logic [7:0] CTL_TAB = 8'h09;
	localparam logic [7:0] CTL_LF  = 8'h0A;
	localparam logic [7:0] CTL_FF  = 8'h0C;
	localparam logic [7:0] CTL_CR  = 8'h0D;
	localparam logic [7:0] CTL_TOP = 8'h1F;

	localparam logic [15:0] HIGH_FIRST = 16'hD800;
	localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
	localparam logic [15:0] LOW_FIRST  = 16'hDC00;
	localparam logic [15:0] LOW_LAST   = 16'hDFFF;

	localparam logic [0:7][7:0] ESCAPE_LETTERS = {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B,
		CH_LOWER_F, CH_N, CH_R, CH_T};

	typedef enum logic [2:0] {
		SCAN_TEXT,
		SCAN_ESCAPE,
		SCAN_HEX_HIGH,
		SCAN_WANT_BSLASH,
		SCAN_WANT_U,
		SCAN_HEX_LOW
	} scan_mode_e;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic [3:0] status;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       typed;
		out_item_t  item;
	} stim_row_t;

	localparam int N_DIRECTED = 27;

	// typed rows carry their single output item; others go through the predictor
	stim_row_t directed_rows [N_DIRECTED] = '{
		'{CH_UPPER_A, 1'b1, '{CH_UPPER_A, 1'b1, ST_CONT, 1'b1}},
		'{CH_MAX,     1'b1, '{CH_MAX, 1'b1, ST_CONT, 1'b1}},
		'{CTL_TOP,    1'b1, '{8'h00, 1'b0, ST_CTRL, 1'b1}},
		'{CH_NUL,     1'b1, '{8'h00, 1'b0, ST_UNT_STR, 1'b1}},
		'{CH_BSLASH,  1'b0, '0},
		'{CH_NUL,     1'b1, '{8'h00, 1'b0, ST_UNT_ESC, 1'b1}},
		'{CH_BSLASH,  1'b0, '0},
		'{CH_X,       1'b1, '{8'h00, 1'b0, ST_BAD_ESC, 1'b1}},
		'{CH_BSLASH,  1'b0, '0},
		'{CH_U,       1'b0, '0},
		'{CH_UPPER_F, 1'b0, '0},
		'{CH_UPPER_F, 1'b0, '0},
		'{CH_LOWER_F, 1'b0, '0},
		'{CH_UPPER_F, 1'b0, '0},
		'{CH_BSLASH,  1'b0, '0},
		'{CH_U,       1'b0, '0},
		'{CH_UPPER_D, 1'b0, '0},
		'{CH_UPPER_B, 1'b0, '0},
		'{CH_UPPER_F, 1'b0, '0},
		'{CH_LOWER_F, 1'b0, '0},
		'{CH_BSLASH,  1'b0, '0},
		'{CH_U,       1'b0, '0},
		'{CH_UPPER_D, 1'b0, '0},
		'{CH_UPPER_F, 1'b0, '0},
		'{CH_UPPER_F, 1'b0, '0},
		'{CH_UPPER_F, 1'b0, '0},
		'{CH_QUOTE,   1'b1, '{8'h00, 1'b0, ST_DONE, 1'b1}}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       pop = 1'b0;
	logic [7:0] char_byte = 8'h00;
	logic       full;
	logic       empty;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic [3:0] status;
	logic       last;

	scan_mode_e scan_mode;
	logic [1:0]  digits_taken;
	logic [15:0] hex_acc;
	logic [9:0]  pending_high;

	out_item_t  expected_items [$];
	logic [7:0] token_bytes [$];

	int  errors = 0;
	int  results_seen = 0;
	int  items_directed = 0;
	int  items_random = 0;
	int  strings_closed = 0;
	int  strings_failed = 0;
	int  cycle_count = 0;
	bit  calm = 1'b0;

	json_string_unescape_utf8 u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.char_byte  (char_byte),
		.empty      (empty),
		.pop        (pop),
		.data_byte  (data_byte),
		.byte_valid (byte_valid),
		.status     (status),
		.last       (last)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic void clear_scan();
		scan_mode    = SCAN_TEXT;
		digits_taken = '0;
		hex_acc      = '0;
		pending_high = '0;
	endfunction

	function automatic int nibble_of(input logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
		if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A) + 10;
		if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
		return -1;
	endfunction

	function automatic int encode_utf8(input logic [20:0] cp, output logic [3:0][7:0] b);
		b = '0;
		if (cp < 21'h80) begin
			b[0] = cp[7:0];
			return 1;
		end
		if (cp < 21'h800) begin
			b[0] = {3'b110, cp[10:6]};
			b[1] = {2'b10, cp[5:0]};
			return 2;
		end
		if (cp < 21'h10000) begin
			b[0] = {4'b1110, cp[15:12]};
			b[1] = {2'b10, cp[11:6]};
			b[2] = {2'b10, cp[5:0]};
			return 3;
		end
		b[0] = {5'b11110, cp[20:18]};
		b[1] = {2'b10, cp[17:12]};
		b[2] = {2'b10, cp[11:6]};
		b[3] = {2'b10, cp[5:0]};
		return 4;
	endfunction

	function automatic void decode_char(input logic [7:0] c, output out_item_t [3:0] items,
			output int count);
		logic [3:0][7:0] bytes;
		logic [3:0]      st;
		logic [15:0]     code;
		logic [20:0]     cp;
		int              n;
		int              d;
		bytes = '0;
		items = '0;
		st = ST_CONT;
		n = 0;
		case (scan_mode)
		SCAN_TEXT: begin
			if (c == CH_NUL) st = ST_UNT_STR;
			else if (c == CH_QUOTE) st = ST_DONE;
			else if (c == CH_BSLASH) scan_mode = SCAN_ESCAPE;
			else if (c < CH_SPACE) st = ST_CTRL;
			else begin
				bytes[0] = c;
				n = 1;
			end
		end
		SCAN_ESCAPE: begin
			scan_mode = SCAN_TEXT;
			case (c)
			CH_NUL: st = ST_UNT_ESC;
			CH_QUOTE, CH_BSLASH, CH_SLASH: begin
				bytes[0] = c;
				n = 1;
			end
			CH_B: begin
				bytes[0] = CTL_BS;
				n = 1;
			end
			CH_LOWER_F: begin
				bytes[0] = CTL_FF;
				n = 1;
			end
			CH_N: begin
				bytes[0] = CTL_LF;
				n = 1;
			end
			CH_R: begin
				bytes[0] = CTL_CR;
				n = 1;
			end
			CH_T: begin
				bytes[0] = CTL_TAB;
				n = 1;
			end
			CH_U: begin
				scan_mode = SCAN_HEX_HIGH;
				digits_taken = '0;
				hex_acc = '0;
			end
			default: st = ST_BAD_ESC;
			endcase
		end
		SCAN_HEX_HIGH, SCAN_HEX_LOW: begin
			d = nibble_of(c);
			if (d < 0) begin
				st = ST_BAD_HEX;
			end else if (digits_taken < 2'd3) begin
				hex_acc = {hex_acc[11:0], 4'(d)};
				digits_taken = digits_taken + 2'd1;
			end else begin
				code = {hex_acc[11:0], 4'(d)};
				digits_taken = '0;
				hex_acc = '0;
				if (scan_mode == SCAN_HEX_HIGH) begin
					if (code >= HIGH_FIRST && code <= HIGH_LAST) begin
						pending_high = code[9:0];
						scan_mode = SCAN_WANT_BSLASH;
					end else if (code >= LOW_FIRST && code <= LOW_LAST) begin
						st = ST_UNP_LOW;
					end else begin
						n = encode_utf8(21'(code), bytes);
						scan_mode = SCAN_TEXT;
					end
				end else begin
					if (code < LOW_FIRST || code > LOW_LAST) begin
						st = ST_BAD_LOW;
					end else begin
						cp = 21'h10000 + {1'b0, pending_high, code[9:0]};
						n = encode_utf8(cp, bytes);
						pending_high = '0;
						scan_mode = SCAN_TEXT;
					end
				end
			end
		end
		SCAN_WANT_BSLASH: begin
			if (c == CH_BSLASH) scan_mode = SCAN_WANT_U;
			else st = ST_UNP_HIGH;
		end
		SCAN_WANT_U: begin
			if (c == CH_U) begin
				scan_mode = SCAN_HEX_LOW;
				digits_taken = '0;
				hex_acc = '0;
			end else begin
				st = ST_UNP_HIGH;
			end
		end
		default: st = ST_UNT_STR;
		endcase
		if (st != ST_CONT) clear_scan();
		if (n == 0) begin
			items[0] = '{8'h00, 1'b0, st, 1'b1};
			count = 1;
		end else begin
			for (int k = 0; k < n; k++) items[k] = '{bytes[k], 1'b1, st, k == n - 1};
			count = n;
		end
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) return CH_ZERO + 8'(v);
		return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + 8'(v) - 8'd10;
	endfunction

	function automatic void add_token_byte(input logic [7:0] c);
		token_bytes.insert(token_bytes.size(), c);
	endfunction

	function automatic void push_unicode(input logic [15:0] code);
		add_token_byte(CH_BSLASH);
		add_token_byte(CH_U);
		for (int i = 3; i >= 0; i--) add_token_byte(hex_char(code[i*4 +: 4]));
	endfunction

	function automatic logic [15:0] random_high();
		return 16'($urandom_range(HIGH_FIRST, HIGH_LAST));
	endfunction

	// one well-formed or deliberately broken piece of string text
	function automatic void build_token();
		int          pick;
		logic [7:0]  c;
		logic [15:0] code;
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			repeat ($urandom_range(1, 4)) begin
				do c = 8'($urandom_range(CH_SPACE, CH_MAX));
				while (c == CH_QUOTE || c == CH_BSLASH);
				add_token_byte(c);
			end
		end else if (pick < 40) begin
			add_token_byte(CH_BSLASH);
			add_token_byte(ESCAPE_LETTERS[$urandom_range(0, 7)]);
		end else if (pick < 55) begin
			case ($urandom_range(0, 9))
			0, 1, 2: code = 16'($urandom_range(0, 16'h7F));
			3, 4, 5: code = 16'($urandom_range(16'h80, 16'h7FF));
			6, 7, 8: code = $urandom_range(0, 1) ? 16'($urandom_range(16'h800, HIGH_FIRST - 1))
				: 16'($urandom_range(LOW_LAST + 1, 16'hFFFF));
			default: code = 16'($urandom_range(LOW_FIRST, LOW_LAST));
			endcase
			push_unicode(code);
		end else if (pick < 70) begin
			push_unicode(random_high());
			if ($urandom_range(0, 5) != 0) code = 16'($urandom_range(LOW_FIRST, LOW_LAST));
			else if ($urandom_range(0, 1)) code = 16'($urandom_range(0, LOW_FIRST - 1));
			else code = 16'($urandom_range(LOW_LAST + 1, 16'hFFFF));
			push_unicode(code);
		end else if (pick < 74) begin
			push_unicode(random_high());
			if ($urandom_range(0, 3) == 0) c = CH_NUL;
			else do c = 8'($urandom()); while (c == CH_BSLASH);
			add_token_byte(c);
		end else if (pick < 78) begin
			push_unicode(random_high());
			add_token_byte(CH_BSLASH);
			if ($urandom_range(0, 3) == 0) c = CH_NUL;
			else do c = 8'($urandom()); while (c == CH_U);
			add_token_byte(c);
		end else if (pick < 82) begin
			add_token_byte(CH_BSLASH);
			add_token_byte(CH_U);
			repeat ($urandom_range(0, 3)) add_token_byte(hex_char(4'($urandom())));
			if ($urandom_range(0, 3) == 0) c = CH_NUL;
			else do c = 8'($urandom()); while (nibble_of(c) >= 0);
			add_token_byte(c);
		end else if (pick < 85) begin
			add_token_byte(CH_BSLASH);
			do c = 8'($urandom());
			while (c inside {CH_NUL, CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_LOWER_F,
				CH_N, CH_R, CH_T, CH_U});
			add_token_byte(c);
		end else if (pick < 88) begin
			add_token_byte(8'($urandom_range(1, CTL_TOP)));
		end else if (pick < 91) begin
			add_token_byte(CH_NUL);
		end else if (pick < 96) begin
			add_token_byte(CH_QUOTE);
		end else begin
			add_token_byte(8'($urandom()));
		end
	endfunction

	task automatic note_failure(input string what, input out_item_t want, input out_item_t got);
		errors++;
		if (errors <= MAX_REPORTS) begin
			$display("%s: expected data=%02h valid=%0d status=%0d last=%0d",
				what, want.data, want.valid, want.status, want.last);
			$display("    got data=%02h valid=%0d status=%0d last=%0d",
				got.data, got.valid, got.status, got.last);
		end
	endtask

	task automatic send_char(input logic [7:0] c, input logic typed, input out_item_t typed_item);
		out_item_t [3:0] items;
		int              count;
		if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			push <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
		end
		push <= 1'b1;
		char_byte <= c;
		do @(posedge clk); while (full);
		decode_char(c, items, count);
		if (typed) expected_items.insert(expected_items.size(), typed_item);
		else for (int k = 0; k < count; k++) expected_items.insert(expected_items.size(), items[k]);
	endtask

	always @(posedge clk) begin : take_results
		out_item_t got;
		out_item_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				got = '{data_byte, byte_valid, status, last};
				results_seen++;
				if (got.last && got.status == ST_DONE) strings_closed++;
				if (got.last && got.status > ST_DONE) strings_failed++;
				if (expected_items.size() == 0) begin
					note_failure("unexpected item", '0, got);
				end else begin
					want = expected_items.pop_front();
					if (got != want) note_failure("mismatch", want, got);
				end
			end
			pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d items still expected",
				cycle_count, expected_items.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin : run
		out_item_t none;
		none = '0;
		clear_scan();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i]) begin
			send_char(directed_rows[i].ch, directed_rows[i].typed, directed_rows[i].item);
			items_directed++;
		end
		while (items_random < RANDOM_ITEMS) begin
			calm = items_random >= CALM_FIRST && items_random < CALM_LAST;
			build_token();
			while (token_bytes.size() > 0) begin
				send_char(token_bytes.pop_front(), 1'b0, none);
				items_random++;
			end
		end
		calm = 1'b0;
		push <= 1'b0;
		while (expected_items.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (expected_items.size() != 0) note_failure("missing item", expected_items.pop_front(), '0);
		$display("Fed %0d directed and %0d random bytes, checked %0d output items.",
			items_directed, items_random, results_seen);
		$display("Strings closed by a quote: %0d, ended by an error status: %0d.",
			strings_closed, strings_failed);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
